// ----- sv/rscl_pkg.sv -----
// Shared types and constants for the strip restart cleaner.
package rscl_pkg;

   localparam logic [31:0] RESTART_MARK = 32'hFFFF_FFFF;
   localparam logic [31:0] COUNT_MAX    = 32'hFFFF_FFFF;

   // word kinds, emitted in ascending bit order
   localparam int EMIT_W       = 5;
   localparam int EMIT_MARKER  = 0;
   localparam int EMIT_FIRST   = 1;
   localparam int EMIT_SECOND  = 2;
   localparam int EMIT_VERTEX  = 3;
   localparam int EMIT_SUMMARY = 4;

   typedef enum logic [3:0] {
      STRIP_SEEK   = 4'b0001,
      STRIP_ONE    = 4'b0010,
      STRIP_TWO    = 4'b0100,
      STRIP_STREAM = 4'b1000
   } strip_state_type;

   typedef struct packed {
      logic [EMIT_W-1:0] mask;
      logic [31:0]       first;
      logic [31:0]       second;
      logic [31:0]       vertex;
      logic [31:0]       total;
   } cmd_type;

endpackage

// ----- sv/rscl_front.sv -----
// Front end: accepts index words, tracks strip state and builds emit commands.
module rscl_front
   import rscl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic [31:0] req_vertex_index,
   input  logic        req_end_of_list,
   input  logic        queue_full,
   output logic        push_valid,
   output cmd_type     push_cmd
);

   strip_state_type state_ff, state_in;
   logic [31:0]     first_ff, first_in;
   logic [31:0]     second_ff, second_in;
   logic            emitted_ff, emitted_in;
   logic [31:0]     count_ff, count_in;
   logic            accept;
   logic            add_tri;
   logic [31:0]     count_inc;

   assign accept    = req_valid && !queue_full;
   assign count_inc = (count_ff == COUNT_MAX) ? count_ff : count_ff + 32'd1;

   always_comb begin
      state_in        = state_ff;
      first_in        = first_ff;
      second_in       = second_ff;
      emitted_in      = emitted_ff;
      add_tri         = 1'b0;
      push_cmd        = '0;
      push_cmd.first  = first_ff;
      push_cmd.second = second_ff;
      push_cmd.vertex = req_vertex_index;
      if (req_vertex_index == RESTART_MARK) begin
         state_in = STRIP_SEEK;
      end else begin
         case (state_ff)
            STRIP_SEEK: begin
               first_in = req_vertex_index;
               state_in = STRIP_ONE;
            end
            STRIP_ONE: begin
               second_in = req_vertex_index;
               state_in  = STRIP_TWO;
            end
            STRIP_TWO: begin
               push_cmd.mask[EMIT_MARKER] = emitted_ff;
               push_cmd.mask[EMIT_FIRST]  = 1'b1;
               push_cmd.mask[EMIT_SECOND] = 1'b1;
               push_cmd.mask[EMIT_VERTEX] = 1'b1;
               add_tri    = 1'b1;
               emitted_in = 1'b1;
               state_in   = STRIP_STREAM;
            end
            STRIP_STREAM: begin
               push_cmd.mask[EMIT_VERTEX] = 1'b1;
               add_tri = 1'b1;
            end
            default: begin
               state_in = STRIP_SEEK;
            end
         endcase
      end
      count_in       = add_tri ? count_inc : count_ff;
      push_cmd.total = count_in;
      if (req_end_of_list) begin
         push_cmd.mask[EMIT_SUMMARY] = 1'b1;
         state_in   = STRIP_SEEK;
         emitted_in = 1'b0;
         count_in   = '0;
      end
   end

   assign push_valid = accept && (push_cmd.mask != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= STRIP_SEEK;
         emitted_ff <= 1'b0;
         count_ff   <= '0;
      end else if (accept) begin
         state_ff   <= state_in;
         emitted_ff <= emitted_in;
         count_ff   <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         first_ff  <= first_in;
         second_ff <= second_in;
      end
   end

endmodule

// ----- sv/rscl_queue.sv -----
// Command queue between the front end and the word emitter.
module rscl_queue
   import rscl_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   input  cmd_type push_cmd,
   input  logic    pop,
   output logic    full,
   output logic    empty,
   output cmd_type head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            entries_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_pop;

   assign full   = (count_ff == CNT_W'(DEPTH));
   assign empty  = (count_ff == '0);
   assign head   = entries_ff[rd_ptr_ff];
   assign do_pop = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push_valid && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !push_valid) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> !full)
      else $error("push into full queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count out of range");

   a_pop_moves: assert property (@(posedge clock) disable iff (reset)
      (do_pop && !push_valid) |=> (count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("pop did not drain queue");

endmodule

// ----- sv/rscl_back.sv -----
// Back end: expands queued commands into output words, one per cycle while rsp is not stalled.
module rscl_back
   import rscl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        empty,
   input  cmd_type     head,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_out_index,
   output logic        rsp_is_summary,
   output logic [31:0] rsp_triangle_total,
   output logic        rsp_last_of_run
);

   logic [EMIT_W-1:0] done_ff, done_in;
   logic [EMIT_W-1:0] rem, sel;
   logic              load, last;
   logic              valid_ff, valid_in;
   logic [31:0]       index_ff, index_in;
   logic              summary_ff;
   logic [31:0]       total_ff, total_in;
   logic              last_ff;

   assign rem  = head.mask & ~done_ff;
   assign sel  = rem & (~rem + EMIT_W'(1));
   assign last = ((rem & ~sel) == '0);
   assign load = !empty && (!valid_ff || !rsp_stall);
   assign pop  = load && last;

   assign valid_in = load || (valid_ff && rsp_stall);

   always_comb begin
      done_in = done_ff;
      if (load) begin
         done_in = last ? '0 : (done_ff | sel);
      end
   end

   always_comb begin
      index_in = '0;
      total_in = '0;
      if (sel[EMIT_MARKER]) begin
         index_in = RESTART_MARK;
      end else if (sel[EMIT_FIRST]) begin
         index_in = head.first;
      end else if (sel[EMIT_SECOND]) begin
         index_in = head.second;
      end else if (sel[EMIT_VERTEX]) begin
         index_in = head.vertex;
      end else begin
         total_in = head.total;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         done_ff  <= done_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         index_ff   <= index_in;
         summary_ff <= sel[EMIT_SUMMARY];
         total_ff   <= total_in;
         last_ff    <= last;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_out_index      = index_ff;
   assign rsp_is_summary     = summary_ff;
   assign rsp_triangle_total = total_ff;
   assign rsp_last_of_run    = last_ff;

   a_head_nonempty: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (head.mask != '0))
      else $error("queued command emits nothing");

   a_done_subset: assert property (@(posedge clock) disable iff (reset)
      (done_ff != '0) |-> (!empty && ((done_ff & ~head.mask) == '0)))
      else $error("emit progress lost its command");

   a_summary_last: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && summary_ff) |-> (last_ff && (index_ff == '0)))
      else $error("summary word not last or carries an index");

endmodule

// ----- sv/strip_restart_cleaner.sv -----
// Top level of the triangle strip restart cleaner.
//
// Input channel req_*: one 32-bit strip vertex index per word, all ones being a
// strip restart, plus an end-of-list flag. Output channel rsp_*: kept indices,
// single restart markers between kept strips, and one summary word carrying the
// saturating triangle total after each end-of-list word. rsp_last_of_run marks
// the final output word caused by one input word.
// Both channels accept a word on a clock edge where valid is high and stall low.
// The first output word of an input word passes through the command queue and
// the output register. Throughput: one input word per cycle while words map
// to at most one output each and rsp is not stalled; the third vertex of a
// strip makes up to four words and an end-of-list up to five, drained one per
// cycle by the emitter unless rsp stalls. A QUEUE_DEPTH-command queue between
// classifier and emitter absorbs bursts; req_stall rises only while it is full.
// A stalled rsp word is held unchanged until taken. Synchronous reset empties
// the queue and output register and restarts strip tracking for a new list.
module strip_restart_cleaner
   import rscl_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_vertex_index,
   input  logic        req_end_of_list,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_out_index,
   output logic        rsp_is_summary,
   output logic [31:0] rsp_triangle_total,
   output logic        rsp_last_of_run
);

   logic    push_valid;
   cmd_type push_cmd;
   logic    queue_full;
   logic    queue_empty;
   cmd_type queue_head;
   logic    queue_pop;

   assign req_stall = queue_full;

   rscl_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_vertex_index (req_vertex_index),
      .req_end_of_list  (req_end_of_list),
      .queue_full       (queue_full),
      .push_valid       (push_valid),
      .push_cmd         (push_cmd)
   );

   rscl_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .pop        (queue_pop),
      .full       (queue_full),
      .empty      (queue_empty),
      .head       (queue_head)
   );

   rscl_back u_back (
      .clock              (clock),
      .reset              (reset),
      .empty              (queue_empty),
      .head               (queue_head),
      .pop                (queue_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_index      (rsp_out_index),
      .rsp_is_summary     (rsp_is_summary),
      .rsp_triangle_total (rsp_triangle_total),
      .rsp_last_of_run    (rsp_last_of_run)
   );

endmodule
